### hdl/pairwise_descriptor_ring_mesh_unit_macros.svh
// assertion macros for the ring mesh top module
`ifndef PAIRWISE_DESCRIPTOR_RING_MESH_UNIT_MACROS_SVH
`define PAIRWISE_DESCRIPTOR_RING_MESH_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PDRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define PDRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pdrm_pkg.sv
`default_nettype none

package pdrm_pkg;

  // mesh size
  localparam int PROCS = 4;
  localparam int DEPTH = 16;

  localparam int PROC_W = $clog2(PROCS);
  localparam int PCNT_W = $clog2(PROCS + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int RING_W = 2 * PROC_W;
  localparam int RINGS  = PROCS * PROCS;
  localparam int ADDR_W = RING_W + IDX_W;
  localparam int WORDS  = RINGS * DEPTH;

  // register and field widths
  localparam int AP_W   = 3;
  localparam int RE_W   = 5;
  localparam int CFG_W  = 5;
  localparam int DESC_W = 64;
  localparam int STAT_W = 3;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PROC_W-1:0] proc_t;
  typedef logic [PCNT_W-1:0] pcnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [RING_W-1:0] ring_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DESC_W-1:0] desc_t;

  typedef enum logic [0:0] {
    CFG_ACTIVE_PROCS = 1'b0,
    CFG_RING_ENTRIES = 1'b1
  } cfg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_TARGET = 3'd2,
    ST_DELIVERED  = 3'd3,
    ST_NOTHING    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_BAD   = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_kind_e;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DRAIN   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             we;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_kind_e kind;
    proc_t     req;
    proc_t     tgt;
    pcnt_t     procs;
    desc_t     desc;
  } cmd_t;

  typedef struct packed {
    status_e status;
    desc_t   desc;
    proc_t   from;
    logic    last;
  } res_t;

  // next slot of a ring, wrapping at the ring size
  function automatic idx_t advance(idx_t i, size_t size);
    size_t n;
    n = size_t'(i) + size_t'(1);
    return (n >= size) ? idx_t'(0) : n[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/pdrm_front.sv
`default_nettype none

module pdrm_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pdrm_pkg::cfg_wr_t cfg_i,
  input  wire              in_valid_i,
  input  wire              in_opcode_i,
  input  pdrm_pkg::proc_t  in_requester_i,
  input  pdrm_pkg::proc_t  in_target_i,
  input  pdrm_pkg::desc_t  in_descriptor_i,
  output pdrm_pkg::cmd_t   cmd_o
);

  pdrm_pkg::pcnt_t             procs_q, procs_d;
  logic [pdrm_pkg::AP_W-1:0]   raw;
  logic                        bad;

  // saturate active_procs into [2, PROCS]
  always_comb begin
    raw     = cfg_i.data[pdrm_pkg::AP_W-1:0];
    procs_d = procs_q;
    if (cfg_i.we && cfg_i.idx == pdrm_pkg::CFG_ACTIVE_PROCS) begin
      if (raw < pdrm_pkg::AP_W'(2)) begin
        procs_d = pdrm_pkg::pcnt_t'(2);
      end else if (raw > pdrm_pkg::AP_W'(pdrm_pkg::PROCS)) begin
        procs_d = pdrm_pkg::pcnt_t'(pdrm_pkg::PROCS);
      end else begin
        procs_d = raw[pdrm_pkg::PCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q <= pdrm_pkg::pcnt_t'(pdrm_pkg::PROCS);
    end else begin
      procs_q <= procs_d;
    end
  end

  // classify the incoming word
  always_comb begin
    bad = (in_target_i == in_requester_i) ||
          (pdrm_pkg::pcnt_t'(in_target_i) >= procs_q) ||
          (pdrm_pkg::pcnt_t'(in_requester_i) >= procs_q);
    cmd_o.req   = in_requester_i;
    cmd_o.tgt   = in_target_i;
    cmd_o.procs = procs_q;
    cmd_o.desc  = in_descriptor_i;
    if (in_opcode_i == pdrm_pkg::OP_ENQUEUE) begin
      cmd_o.kind = bad ? pdrm_pkg::CMD_BAD : pdrm_pkg::CMD_ENQ;
    end else if (pdrm_pkg::pcnt_t'(in_requester_i) >= procs_q) begin
      cmd_o.kind = pdrm_pkg::CMD_NONE;
    end else begin
      cmd_o.kind = pdrm_pkg::CMD_DRAIN;
    end
    // a word with no valid classifies to nothing of use
    if (!in_valid_i) begin
      cmd_o.kind = pdrm_pkg::CMD_NONE;
    end
  end

endmodule

`default_nettype wire

### hdl/pdrm_cmd_queue.sv
`default_nettype none

module pdrm_cmd_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_stall_o,
  input  pdrm_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  wire             pop_i,
  output pdrm_pkg::cmd_t  pop_data_o
);

  pdrm_pkg::cmd_t                 slots_q [pdrm_pkg::QUEUE_DEPTH];
  logic [pdrm_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [pdrm_pkg::QCNT_W-1:0]    cnt_q;
  logic                           push, pop;

  assign push_stall_o = (cnt_q == pdrm_pkg::QCNT_W'(pdrm_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slots_q[rd_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == pdrm_pkg::QPTR_W'(pdrm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                wr_q + pdrm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == pdrm_pkg::QPTR_W'(pdrm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                rd_q + pdrm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + pdrm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - pdrm_pkg::QCNT_W'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/pdrm_back.sv
`default_nettype none

module pdrm_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  pdrm_pkg::cfg_wr_t cfg_i,
  input  wire               cmd_valid_i,
  input  pdrm_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output pdrm_pkg::res_t    res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_e;

  state_e                        state_q;
  pdrm_pkg::size_t               size_q;
  pdrm_pkg::idx_t                head_q [pdrm_pkg::RINGS];
  pdrm_pkg::idx_t                tail_q [pdrm_pkg::RINGS];
  pdrm_pkg::proc_t               recv_q, from_q;
  pdrm_pkg::pcnt_t               dprocs_q;
  logic                          out_valid_q;
  pdrm_pkg::res_t                res_q;

  pdrm_pkg::desc_t               mem [pdrm_pkg::WORDS];
  pdrm_pkg::desc_t               rd_data_q;

  logic [pdrm_pkg::RINGS-1:0]    nonempty;
  logic                          found;
  pdrm_pkg::proc_t               sel_s;
  pdrm_pkg::ring_t               ring_sel;
  pdrm_pkg::idx_t                head_sel, tail_sel, next_tail;
  logic                          full, out_free, mem_we, mem_re;
  logic [pdrm_pkg::RE_W-1:0]     raw;
  pdrm_pkg::size_t               size_sat;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i && out_free;

  // per ring occupancy flags
  always_comb begin
    for (int r = 0; r < pdrm_pkg::RINGS; r++) begin
      nonempty[r] = (head_q[r] != tail_q[r]);
    end
  end

  // lowest sender with a waiting descriptor toward the receiver
  always_comb begin
    found = 1'b0;
    sel_s = '0;
    for (int s = pdrm_pkg::PROCS - 1; s >= 0; s--) begin
      if ((pdrm_pkg::proc_t'(s) != recv_q) &&
          (pdrm_pkg::pcnt_t'(s) < dprocs_q) &&
          nonempty[{recv_q, pdrm_pkg::proc_t'(s)}]) begin
        found = 1'b1;
        sel_s = pdrm_pkg::proc_t'(s);
      end
    end
  end

  // ring under access and its indices
  always_comb begin
    ring_sel  = (state_q == S_IDLE) ? {cmd_i.tgt, cmd_i.req} : {recv_q, sel_s};
    head_sel  = head_q[ring_sel];
    tail_sel  = tail_q[ring_sel];
    next_tail = pdrm_pkg::advance(tail_sel, size_q);
    full      = (next_tail == head_sel);
    mem_we    = cmd_pop_o && (cmd_i.kind == pdrm_pkg::CMD_ENQ) && !full;
    mem_re    = (state_q == S_SCAN) && found;
  end

  // saturate ring_entries into [2, DEPTH]
  always_comb begin
    raw = cfg_i.data[pdrm_pkg::RE_W-1:0];
    if (raw < pdrm_pkg::RE_W'(2)) begin
      size_sat = pdrm_pkg::size_t'(2);
    end else if (raw > pdrm_pkg::RE_W'(pdrm_pkg::DEPTH)) begin
      size_sat = pdrm_pkg::size_t'(pdrm_pkg::DEPTH);
    end else begin
      size_sat = raw[pdrm_pkg::SIZE_W-1:0];
    end
  end

  // sequencer, ring indices and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= pdrm_pkg::size_t'(pdrm_pkg::DEPTH);
      recv_q      <= '0;
      from_q      <= '0;
      dprocs_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      for (int r = 0; r < pdrm_pkg::RINGS; r++) begin
        head_q[r] <= '0;
        tail_q[r] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            res_q.desc <= '0;
            res_q.from <= '0;
            res_q.last <= 1'b1;
            case (cmd_i.kind)
              pdrm_pkg::CMD_BAD: begin
                res_q.status <= pdrm_pkg::ST_BAD_TARGET;
                out_valid_q  <= 1'b1;
              end
              pdrm_pkg::CMD_NONE: begin
                res_q.status <= pdrm_pkg::ST_NOTHING;
                out_valid_q  <= 1'b1;
              end
              pdrm_pkg::CMD_ENQ: begin
                if (full) begin
                  res_q.status <= pdrm_pkg::ST_FULL;
                end else begin
                  tail_q[ring_sel] <= next_tail;
                  res_q.status     <= pdrm_pkg::ST_ACCEPTED;
                end
                out_valid_q <= 1'b1;
              end
              pdrm_pkg::CMD_DRAIN: begin
                recv_q   <= cmd_i.req;
                dprocs_q <= cmd_i.procs;
                state_q  <= S_SCAN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            head_q[ring_sel] <= pdrm_pkg::advance(head_sel, size_q);
            from_q           <= sel_s;
            state_q          <= S_WAIT;
          end else if (out_free) begin
            res_q.status <= pdrm_pkg::ST_NOTHING;
            res_q.desc   <= '0;
            res_q.from   <= '0;
            res_q.last   <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_WAIT: begin
          // heads already advanced, so found means more words remain
          if (out_free) begin
            res_q.status <= pdrm_pkg::ST_DELIVERED;
            res_q.desc   <= rd_data_q;
            res_q.from   <= from_q;
            res_q.last   <= !found;
            out_valid_q  <= 1'b1;
            state_q      <= found ? S_SCAN : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // new ring size empties every ring
      if (cfg_i.we && cfg_i.idx == pdrm_pkg::CFG_RING_ENTRIES) begin
        size_q <= size_sat;
        for (int r = 0; r < pdrm_pkg::RINGS; r++) begin
          head_q[r] <= '0;
          tail_q[r] <= '0;
        end
      end
    end
  end

  // descriptor store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{ring_sel, tail_sel}] <= cmd_i.desc;
    end
    if (mem_re) begin
      rd_data_q <= mem[{ring_sel, head_sel}];
    end
  end

endmodule

`default_nettype wire

### hdl/pairwise_descriptor_ring_mesh_unit.sv
`default_nettype none

// Descriptor ring mesh: one ring per ordered pair of processes, 16 rings of up
// to 16 slots, one slot always kept empty. Input words are classified by a
// front end and held in a two-word command queue; the back end executes them.
// An enqueue, a bad-target enqueue or a drain with an invalid receiver is
// handled in the idle state and gives one result word; they run one per cycle
// while the output is taken. A drain starts from the idle state, then delivers
// each descriptor through a scan step and a wait step for the registered read
// of the descriptor memory, or reports from the scan step that nothing is
// waiting. Writing ring_entries empties all rings at once; the descriptor
// store itself is not cleared and holds nothing meaningful until written.

`include "pairwise_descriptor_ring_mesh_unit_macros.svh"

module pairwise_descriptor_ring_mesh_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration write port
  input  wire                         cfg_we_i,
  input  wire [0:0]                   cfg_idx_i,
  input  wire [pdrm_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input words
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         in_opcode_i,
  input  wire [pdrm_pkg::PROC_W-1:0]  in_requester_i,
  input  wire [pdrm_pkg::PROC_W-1:0]  in_target_i,
  input  wire [pdrm_pkg::DESC_W-1:0]  in_descriptor_i,
  // result words
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [pdrm_pkg::STAT_W-1:0] out_status_o,
  output logic [pdrm_pkg::DESC_W-1:0] out_descriptor_o,
  output logic [pdrm_pkg::PROC_W-1:0] out_from_proc_o,
  output logic                        out_last_o
);

  pdrm_pkg::cfg_wr_t cfg;
  pdrm_pkg::cmd_t    front_cmd, q_cmd;
  pdrm_pkg::res_t    res;
  logic              q_valid, q_pop;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = pdrm_pkg::cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_wdata_i;

  pdrm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_opcode_i     (in_opcode_i),
    .in_requester_i  (in_requester_i),
    .in_target_i     (in_target_i),
    .in_descriptor_i (in_descriptor_i),
    .cmd_o           (front_cmd)
  );

  pdrm_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_cmd)
  );

  pdrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_status_o     = res.status;
  assign out_descriptor_o = res.desc;
  assign out_from_proc_o  = res.from;
  assign out_last_o       = res.last;

  // checks
  `PDRM_ASSERT(a_stall_needs_queue, clk_i, rst_ni, in_stall_o |-> q_valid, "stall with empty queue")
  `PDRM_ASSERT(a_stall_after_push, clk_i, rst_ni, $rose(in_stall_o) |-> $past(in_valid_i), "stall rose without a push")
  `PDRM_ASSERT_NEXT(a_push_fills_queue, clk_i, rst_ni, in_valid_i && !in_stall_o, q_valid, "pushed word lost")
  `PDRM_ASSERT(a_status_word_clean, clk_i, rst_ni, (out_valid_o && (out_status_o != pdrm_pkg::ST_DELIVERED)) |-> (out_last_o && (out_descriptor_o == '0) && (out_from_proc_o == '0)), "status word not final or not clean")

endmodule

`default_nettype wire
